// ===== rtl/core/mtet_pkg.sv =====
// Shared types and constants for the multi-turn encoder tracker.
package mtet_pkg;

    // Slot table depth and field widths
    localparam int MOTOR_SLOTS     = 16;
    localparam int SLOT_W          = 4;
    localparam int BUS_W           = 1;
    localparam int POS_W           = 13;
    localparam int SPEED_W         = 16;
    localparam int CURRENT_W       = 16;
    localparam int COUNT_W         = 33;
    localparam int ANGLE_W         = 45;
    localparam int DELTA_W         = 14;
    localparam int TURN_W          = 20;
    localparam int FRAMES_W        = 8;
    localparam int RATIO_W         = 8;
    localparam int MASK_W          = 16;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 16;

    // Encoder geometry
    localparam int COUNTS_PER_TURN = 8192;
    localparam int HALF_TURN       = COUNTS_PER_TURN / 2;

    // Magnitude of (position - bias) + turns * counts per turn
    localparam int MAG_W           = TURN_W + POS_W;

    // 360 degrees * 2^16 / counts per turn: angle = |m| * scale / ratio
    localparam int ANGLE_SCALE     = 360 * 65536 / COUNTS_PER_TURN;

    // Divider step counter, wide enough for the angle pass
    localparam int STEP_W          = 6;

    localparam logic signed [DELTA_W-1:0] WRAP_HI   = DELTA_W'(HALF_TURN);
    localparam logic signed [DELTA_W-1:0] WRAP_LO   = -WRAP_HI;
    localparam logic [DELTA_W-1:0]        TURN_SPAN = DELTA_W'(COUNTS_PER_TURN);

    localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};
    localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};

    // Register reset values
    localparam logic [FRAMES_W-1:0] BIAS_FRAMES_RESET  = 8'd50;
    localparam logic [RATIO_W-1:0]  RATIO_FIRST_RESET  = 8'd19;
    localparam logic [RATIO_W-1:0]  RATIO_SECOND_RESET = 8'd36;
    localparam logic [MASK_W-1:0]   SECOND_MASK_RESET  = '0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BIAS_FRAMES  = 2'd0,
        CFG_RATIO_FIRST  = 2'd1,
        CFG_RATIO_SECOND = 2'd2,
        CFG_SECOND_MASK  = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MULT,
        ST_DIV_ANGLE,
        ST_DIV_SPEED,
        ST_WRITE
    } state_t;

endpackage

// ===== rtl/core/mtet_frame_if.sv =====
// Motor feedback frame channel.
interface mtet_frame_if;
    logic                                    valid;
    logic                                    ready;
    logic [mtet_pkg::BUS_W-1:0]              bus_number;
    logic [mtet_pkg::SLOT_W-1:0]             motor_slot;
    logic [mtet_pkg::POS_W-1:0]              raw_position;
    logic signed [mtet_pkg::SPEED_W-1:0]     raw_speed;
    logic signed [mtet_pkg::CURRENT_W-1:0]   raw_current;

    modport source (
        output valid, bus_number, motor_slot, raw_position, raw_speed, raw_current,
        input  ready
    );

    modport sink (
        input  valid, bus_number, motor_slot, raw_position, raw_speed, raw_current,
        output ready
    );
endinterface

// ===== rtl/core/mtet_result_if.sv =====
// Tracker result channel.
interface mtet_result_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    calibrating;
    logic signed [mtet_pkg::COUNT_W-1:0]     continuous_count;
    logic signed [mtet_pkg::ANGLE_W-1:0]     angle_q16;
    logic signed [mtet_pkg::DELTA_W-1:0]     step_delta;
    logic signed [mtet_pkg::SPEED_W-1:0]     shaft_speed;
    logic signed [mtet_pkg::CURRENT_W-1:0]   phase_current;

    modport source (
        output valid, calibrating, continuous_count, angle_q16, step_delta,
               shaft_speed, phase_current,
        input  ready
    );

    modport sink (
        input  valid, calibrating, continuous_count, angle_q16, step_delta,
               shaft_speed, phase_current,
        output ready
    );
endinterface

// ===== rtl/core/mtet_cfg_if.sv =====
// Register write channel.
interface mtet_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [mtet_pkg::CFG_INDEX_W-1:0]    index;
    logic [mtet_pkg::CFG_DATA_W-1:0]     data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== rtl/core/multi_turn_motor_encoder_tracker.sv =====
// Multi-turn motor encoder tracker.
// frame:  one motor feedback word per handshake (bus, slot, position, speed, current).
// result: one word per frame: calibrating flag, continuous count, Q16 shaft angle,
//         wrap-corrected delta, geared speed and phase current.
// cfg:    register writes (0 bias_frames, 1 ratio_first, 2 ratio_second,
//         3 second_type_mask), always ready; write only while the block is idle.
// Timing: a calibrating frame goes from the evaluate state straight to the write state.
//         A tracking frame takes one table read and wrap step, one scaling multiply, then
//         a single shared restoring divider (one quotient bit per cycle) runs 45 steps for
//         the angle and 16 steps for the speed, and the write state loads the output
//         register. Frame ready is high only in idle, so a new frame is taken only after
//         the last one's result has been loaded into the output register.
// Stall:  the result sits in an output register until taken; the next frame is
//         accepted meanwhile, and its result waits in the final state until the
//         output register frees up.
// Reset:  registers return to defaults, frame counters, biases, last positions and
//         turn counts clear to zero, no result is pending.
module multi_turn_motor_encoder_tracker (
    input  logic                clk,
    input  logic                rst_n,
    mtet_frame_if.sink          frame,
    mtet_result_if.source       result,
    mtet_cfg_if.sink            cfg
);

    // Configuration registers
    logic [mtet_pkg::FRAMES_W-1:0] bias_frames_reg;
    logic [mtet_pkg::RATIO_W-1:0]  ratio_first_reg;
    logic [mtet_pkg::RATIO_W-1:0]  ratio_second_reg;
    logic [mtet_pkg::MASK_W-1:0]   second_mask_reg;

    // Per-bus and per-slot state
    logic [mtet_pkg::FRAMES_W-1:0]      frames_seen_reg   [2];
    logic [mtet_pkg::POS_W-1:0]         bias_position_reg [mtet_pkg::MOTOR_SLOTS];
    logic [mtet_pkg::POS_W-1:0]         last_position_reg [mtet_pkg::MOTOR_SLOTS];
    logic signed [mtet_pkg::TURN_W-1:0] turn_count_reg    [mtet_pkg::MOTOR_SLOTS];

    // Captured frame
    logic [mtet_pkg::BUS_W-1:0]            bus_reg;
    logic [mtet_pkg::SLOT_W-1:0]           slot_reg;
    logic [mtet_pkg::POS_W-1:0]            pos_reg;
    logic signed [mtet_pkg::SPEED_W-1:0]   speed_reg;
    logic signed [mtet_pkg::CURRENT_W-1:0] current_reg;

    // Evaluated frame
    logic                                  calib_reg;
    logic                                  second_reg;
    logic [mtet_pkg::RATIO_W-1:0]          ratio_reg;
    logic signed [mtet_pkg::TURN_W-1:0]    turns_reg;
    logic [mtet_pkg::DELTA_W-1:0]          delta_reg;
    logic                                  m_neg_reg;
    logic [mtet_pkg::MAG_W-1:0]            m_abs_reg;
    logic                                  speed_neg_reg;
    logic [mtet_pkg::SPEED_W-1:0]          speed_mag_reg;

    // Shared divider
    logic [mtet_pkg::ANGLE_W-1:0]          dq_reg;
    logic [mtet_pkg::ANGLE_W-1:0]          dq_next;
    logic [mtet_pkg::RATIO_W-1:0]          rem_reg;
    logic [mtet_pkg::RATIO_W-1:0]          rem_next;
    logic [mtet_pkg::STEP_W-1:0]           cnt_reg;
    logic [mtet_pkg::ANGLE_W-1:0]          angle_q_reg;
    logic [mtet_pkg::SPEED_W-1:0]          speed_q_reg;

    // Output register
    logic                                  out_valid_reg;
    logic                                  out_calib_reg;
    logic [mtet_pkg::COUNT_W-1:0]          out_count_reg;
    logic [mtet_pkg::ANGLE_W-1:0]          out_angle_reg;
    logic [mtet_pkg::DELTA_W-1:0]          out_delta_reg;
    logic [mtet_pkg::SPEED_W-1:0]          out_speed_reg;
    logic [mtet_pkg::CURRENT_W-1:0]        out_current_reg;

    mtet_pkg::state_t state_reg;
    mtet_pkg::state_t state_next;

    // Sequencer controls
    logic frame_ready;
    logic frame_accept;
    logic div_last;
    logic load_out;

    // Evaluation datapath
    logic                                  calib;
    logic                                  second;
    logic [mtet_pkg::RATIO_W-1:0]          ratio_sel;
    logic [mtet_pkg::RATIO_W-1:0]          ratio_eff;
    logic signed [mtet_pkg::DELTA_W-1:0]   diff;
    logic signed [mtet_pkg::DELTA_W-1:0]   offset;
    logic                                  wrap_up;
    logic                                  wrap_dn;
    logic signed [mtet_pkg::TURN_W-1:0]    turns_cur;
    logic signed [mtet_pkg::TURN_W-1:0]    turns_new;
    logic [mtet_pkg::DELTA_W-1:0]          delta;
    logic [mtet_pkg::MAG_W:0]              m_full;
    logic [mtet_pkg::MAG_W:0]              m_neg_full;
    logic [mtet_pkg::SPEED_W-1:0]          speed_mag;
    logic [mtet_pkg::RATIO_W:0]            div_trial;
    logic [mtet_pkg::RATIO_W:0]            div_diff;
    logic                                  div_ge;

    // Configuration writes, always accepted
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_frames_reg  <= mtet_pkg::BIAS_FRAMES_RESET;
            ratio_first_reg  <= mtet_pkg::RATIO_FIRST_RESET;
            ratio_second_reg <= mtet_pkg::RATIO_SECOND_RESET;
            second_mask_reg  <= mtet_pkg::SECOND_MASK_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (mtet_pkg::cfg_index_t'(cfg.index))
                mtet_pkg::CFG_BIAS_FRAMES:  bias_frames_reg  <= cfg.data[mtet_pkg::FRAMES_W-1:0];
                mtet_pkg::CFG_RATIO_FIRST:  ratio_first_reg  <= cfg.data[mtet_pkg::RATIO_W-1:0];
                mtet_pkg::CFG_RATIO_SECOND: ratio_second_reg <= cfg.data[mtet_pkg::RATIO_W-1:0];
                mtet_pkg::CFG_SECOND_MASK:  second_mask_reg  <= cfg.data[mtet_pkg::MASK_W-1:0];
                default:                    bias_frames_reg  <= bias_frames_reg;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mtet_pkg::ST_IDLE:
                if (frame.valid)
                    state_next = mtet_pkg::ST_EVAL;
            mtet_pkg::ST_EVAL:
                state_next = calib ? mtet_pkg::ST_WRITE : mtet_pkg::ST_MULT;
            mtet_pkg::ST_MULT:
                state_next = mtet_pkg::ST_DIV_ANGLE;
            mtet_pkg::ST_DIV_ANGLE:
                if (cnt_reg == mtet_pkg::STEP_W'(mtet_pkg::ANGLE_W - 1))
                    state_next = mtet_pkg::ST_DIV_SPEED;
            mtet_pkg::ST_DIV_SPEED:
                if (cnt_reg == mtet_pkg::STEP_W'(mtet_pkg::SPEED_W - 1))
                    state_next = mtet_pkg::ST_WRITE;
            mtet_pkg::ST_WRITE:
                if (!out_valid_reg || result.ready)
                    state_next = mtet_pkg::ST_IDLE;
            default:
                state_next = mtet_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        frame_ready = 1'b0;
        div_last    = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            mtet_pkg::ST_IDLE:
                frame_ready = 1'b1;
            mtet_pkg::ST_DIV_ANGLE:
                div_last = (cnt_reg == mtet_pkg::STEP_W'(mtet_pkg::ANGLE_W - 1));
            mtet_pkg::ST_DIV_SPEED:
                div_last = (cnt_reg == mtet_pkg::STEP_W'(mtet_pkg::SPEED_W - 1));
            mtet_pkg::ST_WRITE:
                load_out = !out_valid_reg || result.ready;
            default:
                frame_ready = 1'b0;
        endcase
    end

    assign frame.ready  = frame_ready;
    assign frame_accept = frame.valid && frame_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mtet_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Calibration check, wrap detection and saturating turn step
    always_comb
    begin
        calib     = frames_seen_reg[bus_reg] < bias_frames_reg;
        second    = second_mask_reg[slot_reg];
        ratio_sel = second ? ratio_second_reg : ratio_first_reg;
        ratio_eff = (ratio_sel == '0) ? mtet_pkg::RATIO_W'(1) : ratio_sel;

        diff   = $signed({1'b0, pos_reg}) - $signed({1'b0, last_position_reg[slot_reg]});
        offset = $signed({1'b0, pos_reg}) - $signed({1'b0, bias_position_reg[slot_reg]});

        wrap_up   = diff < mtet_pkg::WRAP_LO;
        wrap_dn   = diff > mtet_pkg::WRAP_HI;
        turns_cur = turn_count_reg[slot_reg];
        turns_new = turns_cur;
        delta     = diff;
        if (wrap_up)
        begin
            delta = diff + mtet_pkg::TURN_SPAN;
            if (turns_cur != mtet_pkg::TURN_MAX)
                turns_new = turns_cur + mtet_pkg::TURN_W'(1);
        end
        else if (wrap_dn)
        begin
            delta = diff - mtet_pkg::TURN_SPAN;
            if (turns_cur != mtet_pkg::TURN_MIN)
                turns_new = turns_cur - mtet_pkg::TURN_W'(1);
        end

        // Offset from bias plus whole turns, then its magnitude
        m_full = {turns_new[mtet_pkg::TURN_W-1], turns_new, {mtet_pkg::POS_W{1'b0}}}
               + {{(mtet_pkg::MAG_W + 1 - mtet_pkg::DELTA_W){offset[mtet_pkg::DELTA_W-1]}},
                  offset};
        m_neg_full = -m_full;

        speed_mag = speed_reg[mtet_pkg::SPEED_W-1] ? -speed_reg : speed_reg;
    end

    // Restoring divide step by the selected ratio
    always_comb
    begin
        div_trial = {rem_reg, dq_reg[mtet_pkg::ANGLE_W-1]};
        div_diff  = div_trial - {1'b0, ratio_reg};
        div_ge    = div_trial >= {1'b0, ratio_reg};
        rem_next  = div_ge ? div_diff[mtet_pkg::RATIO_W-1:0]
                           : div_trial[mtet_pkg::RATIO_W-1:0];
        dq_next   = {dq_reg[mtet_pkg::ANGLE_W-2:0], div_ge};
    end

    // Capture the frame
    always_ff @(posedge clk)
    begin
        if (frame_accept)
        begin
            bus_reg     <= frame.bus_number;
            slot_reg    <= frame.motor_slot;
            pos_reg     <= frame.raw_position;
            speed_reg   <= frame.raw_speed;
            current_reg <= frame.raw_current;
        end
    end

    // Update per-bus counters and per-slot tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_seen_reg[0] <= '0;
            frames_seen_reg[1] <= '0;
            for (int i = 0; i < mtet_pkg::MOTOR_SLOTS; i++)
            begin
                bias_position_reg[i] <= '0;
                last_position_reg[i] <= '0;
                turn_count_reg[i]    <= '0;
            end
        end
        else if (state_reg == mtet_pkg::ST_EVAL)
        begin
            last_position_reg[slot_reg] <= pos_reg;
            if (calib)
            begin
                frames_seen_reg[bus_reg]    <= frames_seen_reg[bus_reg] + mtet_pkg::FRAMES_W'(1);
                bias_position_reg[slot_reg] <= pos_reg;
            end
            else
            begin
                turn_count_reg[slot_reg] <= turns_new;
            end
        end
    end

    // Hold evaluated terms, scale, and run the divider
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            mtet_pkg::ST_EVAL:
            begin
                calib_reg     <= calib;
                second_reg    <= second;
                ratio_reg     <= ratio_eff;
                turns_reg     <= turns_new;
                delta_reg     <= delta;
                m_neg_reg     <= m_full[mtet_pkg::MAG_W];
                m_abs_reg     <= m_full[mtet_pkg::MAG_W]
                                 ? m_neg_full[mtet_pkg::MAG_W-1:0]
                                 : m_full[mtet_pkg::MAG_W-1:0];
                speed_neg_reg <= speed_reg[mtet_pkg::SPEED_W-1];
                speed_mag_reg <= speed_mag;
            end
            mtet_pkg::ST_MULT:
            begin
                dq_reg  <= mtet_pkg::ANGLE_W'(m_abs_reg)
                         * mtet_pkg::ANGLE_W'(mtet_pkg::ANGLE_SCALE);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            mtet_pkg::ST_DIV_ANGLE:
            begin
                if (div_last)
                begin
                    angle_q_reg <= dq_next;
                    dq_reg      <= {speed_mag_reg,
                                    {(mtet_pkg::ANGLE_W - mtet_pkg::SPEED_W){1'b0}}};
                    rem_reg     <= '0;
                    cnt_reg     <= '0;
                end
                else
                begin
                    dq_reg  <= dq_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + mtet_pkg::STEP_W'(1);
                end
            end
            mtet_pkg::ST_DIV_SPEED:
            begin
                dq_reg  <= dq_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + mtet_pkg::STEP_W'(1);
                if (div_last)
                    speed_q_reg <= dq_next[mtet_pkg::SPEED_W-1:0];
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    // Load the result word, restoring signs
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_calib_reg <= calib_reg;
            if (calib_reg)
            begin
                out_count_reg   <= mtet_pkg::COUNT_W'(pos_reg);
                out_angle_reg   <= '0;
                out_delta_reg   <= '0;
                out_speed_reg   <= '0;
                out_current_reg <= '0;
            end
            else
            begin
                out_count_reg   <= {turns_reg, pos_reg};
                out_angle_reg   <= m_neg_reg ? -angle_q_reg : angle_q_reg;
                out_delta_reg   <= delta_reg;
                out_speed_reg   <= speed_neg_reg ? -speed_q_reg : speed_q_reg;
                out_current_reg <= second_reg ? '0 : current_reg;
            end
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.calibrating      = out_calib_reg;
    assign result.continuous_count = out_count_reg;
    assign result.angle_q16        = out_angle_reg;
    assign result.step_delta       = out_delta_reg;
    assign result.shaft_speed      = out_speed_reg;
    assign result.phase_current    = out_current_reg;

endmodule
